@@ rtl/lfpd_pkg.sv @@
// Shared types and constants for the lidar frame point decoder.
package lfpd_pkg;

	localparam int PTS_DEFAULT   = 12;
	localparam int ANGLE_L_POS   = 4;
	localparam int PT_BASE_POS   = 6;
	localparam int FULL_TURN     = 36000;
	localparam int OUT_TDATA_W   = 48;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTENSITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 2'd2;

	localparam logic [7:0]  START_BYTE_RST = 8'h54;
	localparam logic [7:0]  MIN_INT_RST    = 8'h00;
	localparam logic [15:0] MAX_DIST_RST   = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_HDR_W,
		ST_SPAN,
		ST_DIV,
		ST_PT,
		ST_PT_W,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SEL_A0L,
		SEL_A0H,
		SEL_A1L,
		SEL_A1H,
		SEL_DL,
		SEL_DH,
		SEL_INT
	} rd_sel_t;

endpackage

@@ rtl/lidar_frame_point_decoder_top.sv @@
// Lidar frame point decoder: byte stream in, one request per frame point out.
//
// Input: s_tvalid/s_tready/s_tdata carry one sensor byte per request. While
// hunting, bytes are dropped until one equals start_byte; that byte and the
// next 10 + 3*POINTS_PER_FRAME bytes are written into the frame store, one
// byte per cycle. A start byte inside a frame is plain data.
// After the frame's final byte s_tready goes low while the frame is decoded:
// four header reads, one wait, the span reduction, the reciprocal multiply
// for the span per point, then for each point three store reads, one wait
// and one emit. The store's single read port serves all of these reads.
// Output: m_tvalid/m_tready/m_tdata/m_tlast, one request per point, held in
// an output register; tlast marks the frame's final point. A stalled receiver
// holds the decoder in its emit step; once the last point is registered the
// block takes input again while that point still waits.
// Configuration: cfg_we/cfg_index/cfg_wdata, written while idle.
// Reset (arst_n low) returns to hunting with registers at their defaults;
// the frame store is not cleared, every entry is written before it is read.
module lidar_frame_point_decoder_top #(
	parameter int POINTS_PER_FRAME = lfpd_pkg::PTS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [15:0] distance_mm, [23:16] intensity, [39:24] angle_centideg,
	// [43:40] point_index, [47:44] zero
	output logic [lfpd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast,   // last_point
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int FRAME_LEN = 11 + 3 * POINTS_PER_FRAME;
	localparam int END_POS   = lfpd_pkg::PT_BASE_POS + 3 * POINTS_PER_FRAME;
	localparam int AW        = $clog2(FRAME_LEN);
	localparam int DW        = $clog2(POINTS_PER_FRAME);
	localparam int PW        = $clog2(POINTS_PER_FRAME);

	localparam logic [AW-1:0] LAST_POS  = AW'(FRAME_LEN - 1);
	localparam logic [DW:0]   DIV_C     = (DW+1)'(POINTS_PER_FRAME - 1);
	localparam logic [PW-1:0] LAST_PT   = PW'(POINTS_PER_FRAME - 1);
	localparam logic [3:0]    LAST_IDX4 = 4'((POINTS_PER_FRAME - 1) % 16);
	localparam logic [16:0]   TURN17    = 17'(lfpd_pkg::FULL_TURN);

	// configuration
	logic [7:0]  start_byte_q;
	logic [7:0]  min_int_q;
	logic [15:0] max_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= lfpd_pkg::START_BYTE_RST;
			min_int_q    <= lfpd_pkg::MIN_INT_RST;
			max_dist_q   <= lfpd_pkg::MAX_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lfpd_pkg::REG_START_BYTE:    start_byte_q <= cfg_wdata[7:0];
				lfpd_pkg::REG_MIN_INTENSITY: min_int_q    <= cfg_wdata[7:0];
				lfpd_pkg::REG_MAX_DISTANCE:  max_dist_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lfpd_pkg::state_t  state_q, state_nx;
	logic              in_frame_q;
	logic [AW-1:0]     pos_q;
	logic [1:0]        k_q;
	logic [PW-1:0]     pi_q;
	logic [AW-1:0]     pt_addr_q;

	logic              in_acc;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	lfpd_pkg::rd_sel_t rd_sel;
	logic [7:0]        rdata;
	logic              rd_vld_s1;
	lfpd_pkg::rd_sel_t rd_sel_s1;

	logic              div_start;
	logic              div_done;
	logic [15:0]       div_quot;
	logic [DW-1:0]     div_rem;
	logic [15:0]       span;

	logic              out_free;
	logic              frame_end;

	// read data lands in the cycle after the address
	logic [15:0] a0_q, a1_q, dist_q;
	logic [7:0]  int_q;

	assign in_acc    = s_tvalid && s_tready;
	assign frame_end = in_acc && in_frame_q && (pos_q == LAST_POS);
	assign out_free  = !m_tvalid || m_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lfpd_pkg::ST_IDLE:  if (frame_end) state_nx = lfpd_pkg::ST_HDR;
			lfpd_pkg::ST_HDR:   if (k_q == 2'd3) state_nx = lfpd_pkg::ST_HDR_W;
			lfpd_pkg::ST_HDR_W: state_nx = lfpd_pkg::ST_SPAN;
			lfpd_pkg::ST_SPAN:  state_nx = lfpd_pkg::ST_DIV;
			lfpd_pkg::ST_DIV:   if (div_done) state_nx = lfpd_pkg::ST_PT;
			lfpd_pkg::ST_PT:    if (k_q == 2'd2) state_nx = lfpd_pkg::ST_PT_W;
			lfpd_pkg::ST_PT_W:  state_nx = lfpd_pkg::ST_EMIT;
			lfpd_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nx = (pi_q == LAST_PT) ? lfpd_pkg::ST_IDLE : lfpd_pkg::ST_PT;
				end
			end
			default: state_nx = lfpd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		rd_sel    = lfpd_pkg::SEL_A0L;
		div_start = 1'b0;
		case (state_q)
			lfpd_pkg::ST_IDLE: s_tready = 1'b1;
			lfpd_pkg::ST_HDR: begin
				rd_en = 1'b1;
				case (k_q)
					2'd0: begin
						rd_addr = AW'(lfpd_pkg::ANGLE_L_POS);
						rd_sel  = lfpd_pkg::SEL_A0L;
					end
					2'd1: begin
						rd_addr = AW'(lfpd_pkg::ANGLE_L_POS + 1);
						rd_sel  = lfpd_pkg::SEL_A0H;
					end
					2'd2: begin
						rd_addr = AW'(END_POS);
						rd_sel  = lfpd_pkg::SEL_A1L;
					end
					default: begin
						rd_addr = AW'(END_POS + 1);
						rd_sel  = lfpd_pkg::SEL_A1H;
					end
				endcase
			end
			lfpd_pkg::ST_SPAN: div_start = 1'b1;
			lfpd_pkg::ST_PT: begin
				rd_en   = 1'b1;
				rd_addr = pt_addr_q + AW'(k_q);
				case (k_q)
					2'd0:    rd_sel = lfpd_pkg::SEL_DL;
					2'd1:    rd_sel = lfpd_pkg::SEL_DH;
					default: rd_sel = lfpd_pkg::SEL_INT;
				endcase
			end
			default: ;
		endcase
	end

	// capture side of the frame: writes only while idle, reads only while decoding
	assign mem_we    = in_acc && (in_frame_q || (s_tdata == start_byte_q));
	assign mem_waddr = in_frame_q ? pos_q : '0;

	lfpd_frame_mem #(
		.DEPTH (FRAME_LEN),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// span = (end - start) folded into one turn; a negative difference wraps by a full turn
	always_comb begin
		logic signed [17:0] d;
		d = $signed({2'b00, a1_q}) - $signed({2'b00, a0_q});
		if (d < 0) d = d + 18'sd36000;
		if (d < 0) d = -d;
		if (d >= 18'sd36000) d = d - 18'sd36000;
		span = d[15:0];
	end

	lfpd_div #(
		.DW      (DW),
		.DIVISOR (POINTS_PER_FRAME - 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lfpd_pkg::ST_IDLE;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			k_q        <= '0;
			pi_q       <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			if (in_acc) begin
				if (!in_frame_q) begin
					if (s_tdata == start_byte_q) begin
						in_frame_q <= 1'b1;
						pos_q      <= AW'(1);
					end
				end else if (pos_q == LAST_POS) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					pos_q <= pos_q + AW'(1);
				end
			end
			if ((state_q == lfpd_pkg::ST_HDR) || (state_q == lfpd_pkg::ST_PT)) begin
				k_q <= (state_nx == state_q) ? k_q + 2'd1 : 2'd0;
			end
			if (state_q == lfpd_pkg::ST_SPAN) begin
				pi_q <= '0;
			end else if (state_q == lfpd_pkg::ST_EMIT && out_free) begin
				pi_q <= pi_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			case (rd_sel_s1)
				lfpd_pkg::SEL_A0L: a0_q[7:0]    <= rdata;
				lfpd_pkg::SEL_A0H: a0_q[15:8]   <= rdata;
				lfpd_pkg::SEL_A1L: a1_q[7:0]    <= rdata;
				lfpd_pkg::SEL_A1H: a1_q[15:8]   <= rdata;
				lfpd_pkg::SEL_DL:  dist_q[7:0]  <= rdata;
				lfpd_pkg::SEL_DH:  dist_q[15:8] <= rdata;
				lfpd_pkg::SEL_INT: int_q        <= rdata;
				default: ;
			endcase
		end
		rd_sel_s1 <= rd_sel;
	end

	// angle offset i*span/(N-1) kept as quotient and remainder, stepped per point
	logic [15:0]   q_acc_q;
	logic [DW-1:0] r_acc_q;
	logic [DW:0]   r_sum;
	logic          r_carry;
	logic [DW:0]   r_wrap;
	logic [16:0]   ang_sum;
	logic [16:0]   ang_fix;
	logic [15:0]   dist_out;
	logic [7:0]    int_out;
	logic [PW+3:0] pi_ext;

	always_comb begin
		r_sum   = {1'b0, r_acc_q} + {1'b0, div_rem};
		r_carry = (r_sum >= DIV_C);
		r_wrap  = r_carry ? (r_sum - DIV_C) : r_sum;
		ang_sum = {1'b0, a0_q} + {1'b0, q_acc_q};
		ang_fix = (ang_sum > TURN17) ? (ang_sum - TURN17) : ang_sum;
		dist_out = (dist_q == 16'd0) ? max_dist_q : dist_q;
		int_out  = (int_q < min_int_q) ? 8'd0 : int_q;
		pi_ext   = {4'b0000, pi_q};
	end

	always_ff @(posedge clk) begin
		if (state_q == lfpd_pkg::ST_SPAN) begin
			pt_addr_q <= AW'(lfpd_pkg::PT_BASE_POS);
			q_acc_q   <= '0;
			r_acc_q   <= '0;
		end else if (state_q == lfpd_pkg::ST_EMIT && out_free) begin
			pt_addr_q <= pt_addr_q + AW'(3);
			q_acc_q   <= q_acc_q + div_quot + {15'd0, r_carry};
			r_acc_q   <= r_wrap[DW-1:0];
		end
	end

	// output register
	logic                             m_tvalid_q;
	logic [lfpd_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                             m_tlast_q;
	logic                             load;

	assign load = (state_q == lfpd_pkg::ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {4'b0000, pi_ext[3:0], ang_fix[15:0], int_out, dist_out};
			m_tlast_q <= (pi_q == LAST_PT);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[43:40] == LAST_IDX4)
		else $error("tlast on a point that is not the frame's final one");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == lfpd_pkg::ST_DIV)
		else $error("divider finished outside its wait step");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |=> state_q == lfpd_pkg::ST_HDR && !s_tready)
		else $error("frame end did not start decoding");
`endif

endmodule

@@ rtl/lfpd_frame_mem.sv @@
// Frame byte store: one write port, one registered read port.
module lfpd_frame_mem #(
	parameter int DEPTH = 47,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lfpd_div.sv @@
// Span per point: reciprocal multiply by the constant point spacing count.
module lfpd_div #(
	parameter int DW      = 4,
	parameter int DIVISOR = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [15:0]    dividend,
	output logic           done,
	output logic [15:0]    quot,
	output logic [DW-1:0]  rem
);

	// m = ceil(2^(16+l)/d) with l = ceil(log2 d) is exact for every 16-bit dividend
	localparam int          SH     = 16 + $clog2(DIVISOR);
	localparam int          PRW    = SH + 16;
	localparam int          MULT   = ((1 << SH) + DIVISOR - 1) / DIVISOR;
	localparam logic [16:0] MULT_C = 17'(MULT);
	localparam logic [15:0] DIV_C  = 16'(DIVISOR);

	logic [PRW-1:0] prod_s1;
	logic [15:0]    dvd_s1;
	logic           vld_s1;
	logic [15:0]    quot_q;
	logic [DW-1:0]  rem_q;
	logic           done_q;
	logic [15:0]    q_est;
	logic [15:0]    q_times_d;
	logic [15:0]    rem_full;

	always_comb begin
		q_est     = prod_s1[SH +: 16];
		q_times_d = q_est * DIV_C;
		rem_full  = dvd_s1 - q_times_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PRW'(dividend) * PRW'(MULT_C);
			dvd_s1  <= dividend;
		end
		if (vld_s1) begin
			quot_q <= q_est;
			rem_q  <= rem_full[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
